FILE: design/sis_pkg.sv
// shared types and constants for the substring index search block
package sis_pkg;

    localparam int MAX_PATTERN_DEF = 64;
    localparam int MAX_TEXT_DEF    = 4096;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_PATTERN = 2'd1;
    localparam logic [1:0] OP_TEXT    = 2'd2;
    localparam logic [1:0] OP_FINISH  = 2'd3;

    typedef struct packed {
        logic shift_text;
        logic shift_pat;
    } t_cell_ctl;

endpackage

FILE: design/sis_cell.sv
// one window cell: a text char and the pattern char aligned with it
module sis_cell import sis_pkg::*; #(
    parameter int IDX = 0,
    parameter int LW  = 7
) (
    input  logic            i_clk,
    input  t_cell_ctl       i_ctl,
    input  logic [LW-1:0]   i_len,
    input  logic [7:0]      i_text,
    input  logic [7:0]      i_pat,
    output logic [7:0]      o_text,
    output logic [7:0]      o_pat,
    output logic            o_ok
);

    logic [7:0] r_text;
    logic [7:0] r_pat;
    logic       active;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_text) begin
            r_text <= i_text;
        end
        if (i_ctl.shift_pat) begin
            r_pat <= i_pat;
        end
    end

    // cells at or beyond the pattern length take no part in the compare
    assign active = (LW'(IDX) < i_len);
    assign o_ok   = !active || (r_text == r_pat);
    assign o_text = r_text;
    assign o_pat  = r_pat;

endmodule

FILE: design/substring_index_search.sv
// Streaming substring search (INDEX): a row of window cells and the match bookkeeping.
// One input channel (i_in_valid / o_in_ready) carries opcode, ch and backward.
// Opcodes: clear starts a new search, pattern appends one pattern char, text
// streams one text char, finish reports one result on the output channel
// (o_out_valid / i_out_ready) as position and overflow.
// A new beat is accepted in every cycle while the
// output register is empty or being drained in the same cycle.
// Each cell holds one text char and the pattern char aligned with it; text
// chars shift one cell per text beat and pattern chars one cell per pattern beat. The window is compared in the cycle
// after a text beat, and that match is forwarded to a finish in that cycle.
// A finish result shows on the output in the cycle after its beat.
// Position is the 1-based first (forward) or last (backward) match start, 0
// if none; an empty pattern gives 1 forward and text length + 1 backward.
// Chars beyond MAX_PATTERN or MAX_TEXT are dropped and set overflow.
// Reset (synchronous, active low) empties the search and the output register;
// no clearing pass is needed. A stalled receiver holds the result stable and,
// once the output register is full, holds off further input beats.
module substring_index_search import sis_pkg::*; #(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int MAX_TEXT    = MAX_TEXT_DEF,
    parameter int PW          = $clog2(MAX_TEXT + 2)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_opcode,
    input  logic [7:0]    i_ch,
    input  logic          i_backward,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [PW-1:0] o_position,
    output logic          o_overflow
);

    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int MW = (PW > LW) ? PW : LW;

    logic [LW-1:0] r_len,   n_len;
    logic [PW-1:0] r_count, n_count;
    logic [PW-1:0] r_first, n_first;
    logic [PW-1:0] r_last,  n_last;
    logic          r_ovf,   n_ovf;
    logic          r_chk,   n_chk;
    logic          r_out_valid, n_out_valid;
    logic [PW-1:0] r_pos,   n_pos;
    logic          r_out_ovf, n_out_ovf;

    logic          beat;
    logic          pat_full;
    logic          text_full;
    t_cell_ctl     ctl;
    logic [7:0]    w_text [MAX_PATTERN];
    logic [7:0]    w_pat  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_ok;
    logic [MW-1:0] count_ext;
    logic [MW-1:0] len_ext;
    logic          hit;
    logic [PW-1:0] start;
    logic [PW-1:0] eff_first;
    logic [PW-1:0] eff_last;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign beat       = i_in_valid && o_in_ready;
    assign pat_full   = (r_len == LW'(MAX_PATTERN));
    assign text_full  = (r_count >= PW'(MAX_TEXT));

    assign ctl.shift_text = beat && (i_opcode == OP_TEXT) && !text_full;
    assign ctl.shift_pat  = beat && (i_opcode == OP_PATTERN) && !pat_full;

    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic [7:0] text_in;
            logic [7:0] pat_in;
            if (k == 0) begin : g_head
                assign text_in = i_ch;
                assign pat_in  = i_ch;
            end else begin : g_link
                assign text_in = w_text[k-1];
                assign pat_in  = w_pat[k-1];
            end
            sis_cell #(
                .IDX (k),
                .LW  (LW)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (ctl),
                .i_len  (r_len),
                .i_text (text_in),
                .i_pat  (pat_in),
                .o_text (w_text[k]),
                .o_pat  (w_pat[k]),
                .o_ok   (w_ok[k])
            );
        end
    endgenerate

    // compare of the window left by the previous text beat
    assign count_ext = MW'(r_count);
    assign len_ext   = MW'(r_len);
    assign hit       = r_chk && (r_len != '0) && (count_ext >= len_ext) && (&w_ok);
    assign start     = PW'(count_ext - len_ext + MW'(1));
    assign eff_first = (hit && (r_first == '0)) ? start : r_first;
    assign eff_last  = hit ? start : r_last;

    always_comb begin
        n_len       = r_len;
        n_count     = r_count;
        n_first     = eff_first;
        n_last      = eff_last;
        n_ovf       = r_ovf;
        n_chk       = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_pos       = r_pos;
        n_out_ovf   = r_out_ovf;
        if (beat) begin
            case (i_opcode)
                OP_CLEAR: begin
                    n_len   = '0;
                    n_count = '0;
                    n_first = '0;
                    n_last  = '0;
                    n_ovf   = 1'b0;
                end
                OP_PATTERN: begin
                    if (pat_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_len = r_len + LW'(1);
                    end
                end
                OP_TEXT: begin
                    if (text_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + PW'(1);
                        n_chk   = 1'b1;
                    end
                end
                OP_FINISH: begin
                    n_out_valid = 1'b1;
                    n_out_ovf   = r_ovf;
                    if (r_len == '0) begin
                        n_pos = i_backward ? (r_count + PW'(1)) : PW'(1);
                    end else if (count_ext < len_ext) begin
                        n_pos = '0;
                    end else begin
                        n_pos = i_backward ? eff_last : eff_first;
                    end
                end
                default: begin
                    n_len = r_len;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_count     <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_ovf       <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_count     <= n_count;
            r_first     <= n_first;
            r_last      <= n_last;
            r_ovf       <= n_ovf;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_out_ovf <= n_out_ovf;
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_pos;
    assign o_overflow  = r_out_ovf;

endmodule

FILE: design/sis_checker.sv
// port-level checks for the substring index search block, bound to the top level
module sis_checker import sis_pkg::*; #(
    parameter int MAX_TEXT = MAX_TEXT_DEF,
    parameter int PW       = $clog2(MAX_TEXT + 2)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic [1:0]    i_opcode,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic [PW-1:0] o_position,
    input logic          o_overflow
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_position)
            && $stable(o_overflow))
        else $error("result changed while stalled");

    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_beat && (i_opcode == OP_FINISH)))
        else $error("result without a finish beat");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input held off with empty output register");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_position <= PW'(MAX_TEXT + 1)))
        else $error("position beyond text limit");

    // finish right after clear sees an empty pattern and empty text
    a_clear_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_opcode == OP_CLEAR)) ##1 (in_beat && (i_opcode == OP_FINISH))
            |=> (o_position == PW'(1)) && !o_overflow)
        else $error("wrong result after clear");

endmodule

bind substring_index_search sis_checker #(
    .MAX_TEXT (MAX_TEXT),
    .PW       (PW)
) u_sis_checker (.*);

FILE: tb/tb.sv
// self-checking testbench for the streaming substring index search block
module tb;
    import sis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW         = $clog2(MAX_TEXT_DEF + 2);
    localparam int WATCH_MAX  = 1000;
    localparam int RAND_BEATS = 285;

    typedef struct {
        logic [PW-1:0] pos;
        logic          ovf;
    } t_index_result;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          i_in_valid;
    logic          o_in_ready;
    logic [1:0]    i_opcode;
    logic [7:0]    i_ch;
    logic          i_backward;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    logic [PW-1:0] o_position;
    logic          o_overflow;

    substring_index_search u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_ch        (i_ch),
        .i_backward  (i_backward),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_position  (o_position),
        .o_overflow  (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // search state tracked by the testbench
    logic [7:0]    pat_mem [MAX_PATTERN_DEF];
    logic [7:0]    text_win [MAX_PATTERN_DEF];  // entry 0 is the newest char
    int unsigned   pat_len;
    int unsigned   text_len;
    int unsigned   first_pos;
    int unsigned   last_pos;
    logic          dropped;

    t_index_result index_results[$];
    t_index_result got_want;
    int            err_cnt;
    int            beat_cnt;
    int            send_idle_pct = 30;
    int            recv_idle_pct = 53;
    int            idle_cycles = 0;

    function automatic void clear_search();
        for (int k = 0; k < MAX_PATTERN_DEF; k++) begin
            pat_mem[k]  = 8'h00;
            text_win[k] = 8'h00;
        end
        pat_len   = 0;
        text_len  = 0;
        first_pos = 0;
        last_pos  = 0;
        dropped   = 1'b0;
    endfunction

    function automatic void search_step(input logic [1:0] op, input logic [7:0] ch,
                                        input logic bwd);
        bit            hit;
        int unsigned   pos;
        t_index_result res;
        case (op)
            OP_CLEAR: begin
                clear_search();
            end
            OP_PATTERN: begin
                if (pat_len < MAX_PATTERN_DEF) begin
                    pat_mem[pat_len] = ch;
                    pat_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            OP_TEXT: begin
                if (text_len >= MAX_TEXT_DEF) begin
                    dropped = 1'b1;
                end else begin
                    for (int k = MAX_PATTERN_DEF - 1; k > 0; k--)
                        text_win[k] = text_win[k-1];
                    text_win[0] = ch;
                    text_len++;
                    if (pat_len != 0 && text_len >= pat_len) begin
                        hit = 1'b1;
                        for (int j = 0; j < pat_len; j++)
                            if (text_win[pat_len-1-j] != pat_mem[j])
                                hit = 1'b0;
                        if (hit) begin
                            if (first_pos == 0)
                                first_pos = text_len - pat_len + 1;
                            last_pos = text_len - pat_len + 1;
                        end
                    end
                end
            end
            OP_FINISH: begin
                if (pat_len == 0)
                    pos = bwd ? text_len + 1 : 1;
                else if (text_len < pat_len)
                    pos = 0;
                else
                    pos = bwd ? last_pos : first_pos;
                res.pos = pos[PW-1:0];
                res.ovf = dropped;
                index_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    // one input beat; valid stays high from the previous beat unless the sender idles
    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch, input logic bwd);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_ch       <= ch;
        i_backward <= bwd;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        search_step(op, ch, bwd);
        beat_cnt++;
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (index_results.size() != 0);
    endtask

    always @(posedge i_clk)
        i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (index_results.size() == 0) begin
                report_mismatch("unexpected result, position", int'(o_position), 0);
            end else begin
                got_want = index_results.pop_front();
                if (o_position !== got_want.pos)
                    report_mismatch("position", int'(o_position), int'(got_want.pos));
                if (o_overflow !== got_want.ovf)
                    report_mismatch("overflow", int'(o_overflow), int'(got_want.ovf));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // finish straight out of reset, then an empty pattern over a short text
    task automatic test_empty_pattern();
        send_beat(OP_FINISH, 8'h00, 1'b0);
        send_beat(OP_CLEAR, 8'hFF, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_TEXT, 8'hFF, 1'b0);
        send_beat(OP_FINISH, 8'hFF, 1'b1);
    endtask

    task automatic test_short_text();
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        send_beat(OP_PATTERN, 8'hFF, 1'b1);
        send_beat(OP_PATTERN, 8'h00, 1'b0);
        send_beat(OP_TEXT, 8'hFF, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b0);
    endtask

    // overlapping matches, repeated finish, pattern grown after text
    task automatic test_matches();
        logic [7:0] txt [6] = '{8'h61, 8'h61, 8'h61, 8'h62, 8'h61, 8'h61};
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        send_beat(OP_PATTERN, 8'h61, 1'b0);
        send_beat(OP_PATTERN, 8'h61, 1'b1);
        foreach (txt[k])
            send_beat(OP_TEXT, txt[k], 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_PATTERN, 8'h62, 1'b0);
        send_beat(OP_TEXT, 8'h61, 1'b0);
        send_beat(OP_TEXT, 8'h61, 1'b0);
        send_beat(OP_TEXT, 8'h62, 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b0);
    endtask

    // a full-length pattern plus two dropped chars, then found in the text
    task automatic test_pattern_full();
        logic [7:0] pat [MAX_PATTERN_DEF];
        foreach (pat[k])
            pat[k] = 8'($urandom);
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        foreach (pat[k])
            send_beat(OP_PATTERN, pat[k], 1'($urandom_range(0, 1)));
        send_beat(OP_PATTERN, 8'($urandom), 1'b0);
        send_beat(OP_PATTERN, 8'($urandom), 1'b1);
        for (int k = 0; k < 10; k++)
            send_beat(OP_TEXT, 8'($urandom), 1'b0);
        foreach (pat[k])
            send_beat(OP_TEXT, pat[k], 1'b0);
        send_beat(OP_TEXT, 8'($urandom), 1'b0);
        foreach (pat[k])
            send_beat(OP_TEXT, pat[k], 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b0);
    endtask

    // text past the limit, with an empty pattern and with a short one
    task automatic test_text_full();
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        for (int k = 0; k < MAX_TEXT_DEF + 2; k++)
            send_beat(OP_TEXT, 8'h5A ^ 8'($urandom_range(0, 1)), 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b0);
        send_beat(OP_PATTERN, 8'h5A, 1'b0);
        send_beat(OP_TEXT, 8'h5A, 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        wait_drain();
        send_beat(OP_CLEAR, 8'h00, 1'b0);
        send_beat(OP_PATTERN, 8'h5A, 1'b0);
        send_beat(OP_PATTERN, 8'h5B, 1'b0);
        send_beat(OP_PATTERN, 8'h5A, 1'b0);
        for (int k = 0; k < MAX_TEXT_DEF + 1; k++)
            send_beat(OP_TEXT, 8'h5A ^ 8'($urandom_range(0, 1)), 1'b0);
        send_beat(OP_FINISH, 8'h00, 1'b1);
        send_beat(OP_FINISH, 8'h00, 1'b0);
    endtask

    // mostly well-formed searches over a two-letter alphabet, some noise mixed in
    task automatic test_random_searches(input int n_beats);
        int         start_cnt;
        int         plen;
        int         tlen;
        int         sent;
        logic [7:0] base;
        logic [7:0] pat [MAX_PATTERN_DEF];
        start_cnt = beat_cnt;
        while (beat_cnt - start_cnt < n_beats) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 5))
                    send_beat(2'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
                continue;
            end
            if ($urandom_range(0, 5) == 0)
                wait_drain();
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, MAX_PATTERN_DEF)
                                                : $urandom_range(0, 6);
            tlen = $urandom_range(0, 40);
            base = 8'($urandom);
            // a missing clear carries the previous search along
            if ($urandom_range(0, 9) != 0)
                send_beat(OP_CLEAR, 8'($urandom), 1'($urandom_range(0, 1)));
            for (int k = 0; k < plen; k++) begin
                pat[k] = base ^ 8'($urandom_range(0, 1));
                send_beat(OP_PATTERN, pat[k], 1'($urandom_range(0, 1)));
            end
            sent = 0;
            while (sent < tlen) begin
                if (plen > 0 && $urandom_range(0, 3) == 0) begin
                    for (int k = 0; k < plen; k++)
                        send_beat(OP_TEXT, pat[k], 1'($urandom_range(0, 1)));
                    sent += plen;
                end else if ($urandom_range(0, 29) == 0) begin
                    send_beat(OP_PATTERN, base ^ 8'($urandom_range(0, 1)), 1'b0);
                end else begin
                    send_beat(OP_TEXT, base ^ 8'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            repeat ($urandom_range(1, 3))
                send_beat(OP_FINISH, 8'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_CLEAR;
        i_ch        <= 8'h00;
        i_backward  <= 1'b0;
        err_cnt     = 0;
        beat_cnt    = 0;
        clear_search();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_short_text();
        test_matches();
        test_pattern_full();
        test_text_full();
        test_random_searches(RAND_BEATS);
        wait_drain();
        send_idle_pct = 53;
        recv_idle_pct = 30;
        test_random_searches(RAND_BEATS);
        wait_drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_searches(RAND_BEATS);

        wait_drain();
        repeat (5) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
